FILE: src/mtt_pkg.sv
package mtt_pkg;

	// Default table depth.
	localparam int MAX_TIMERS_DEF = 16;

	// Field widths.
	localparam int ID_W    = 16;
	localparam int IVL_W   = 31;
	localparam int ELAP_W  = 32;
	localparam int DELTA_W = 16;

	// Operation codes of an input beat.
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Status codes of a result beat.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DUP       = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_DISABLED  = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EMIT = 1'b1
	} state_t;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                     add;
		logic                     remove;
		logic                     tick;
		logic                     emit_shift;
		logic [ID_W-1:0]          key_id;
		logic [IVL_W-1:0]         new_interval;
		logic [DELTA_W-1:0]       delta;
	} cell_ctrl_t;

endpackage

FILE: src/mtt_cell.sv
module mtt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtt_pkg::cell_ctrl_t           ctrl,
	input  logic                          valid,
	input  logic                          load_sel,
	input  logic                          match_in,
	input  logic [mtt_pkg::ID_W-1:0]      nxt_id,
	input  logic [mtt_pkg::IVL_W-1:0]     nxt_interval,
	input  logic [mtt_pkg::ELAP_W-1:0]    nxt_elapsed,
	input  logic                          nxt_fire,
	input  logic [mtt_pkg::ID_W-1:0]      nxt_fire_id,
	output logic [mtt_pkg::ID_W-1:0]      id,
	output logic [mtt_pkg::IVL_W-1:0]     interval,
	output logic [mtt_pkg::ELAP_W-1:0]    elapsed,
	output logic                          match_out,
	output logic                          fire,
	output logic [mtt_pkg::ID_W-1:0]      fire_id
);

	logic [mtt_pkg::ID_W-1:0]   id_q;
	logic [mtt_pkg::IVL_W-1:0]  interval_q;
	logic [mtt_pkg::ELAP_W-1:0] elapsed_q;
	logic                       fire_q;
	logic [mtt_pkg::ID_W-1:0]   fire_id_q;
	logic [mtt_pkg::ELAP_W-1:0] sum;
	logic                       reached;
	logic                       match;

	// A live entry matches the broadcast id; the chain marks this cell and all after a match.
	assign match     = valid && (id_q == ctrl.key_id);
	assign match_out = match_in | match;

	// Elapsed count after this tick and whether it reaches the interval.
	assign sum     = elapsed_q + {{(mtt_pkg::ELAP_W-mtt_pkg::DELTA_W){1'b0}}, ctrl.delta};
	assign reached = sum >= {1'b0, interval_q};

	// Entry storage: load on add, take the neighbor's entry on remove, advance on tick.
	always_ff @(posedge clk) begin
		if (ctrl.add && load_sel) begin
			id_q       <= ctrl.key_id;
			interval_q <= ctrl.new_interval;
			elapsed_q  <= '0;
		end else if (ctrl.remove && match_out) begin
			id_q       <= nxt_id;
			interval_q <= nxt_interval;
			elapsed_q  <= nxt_elapsed;
		end else if (ctrl.tick && valid) begin
			elapsed_q <= reached ? '0 : sum;
		end
	end

	// Fire chain: loaded on tick, then shifted toward the head one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_q <= 1'b0;
		end else if (ctrl.tick) begin
			fire_q <= valid && reached;
		end else if (ctrl.emit_shift) begin
			fire_q <= nxt_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tick) begin
			fire_id_q <= id_q;
		end else if (ctrl.emit_shift) begin
			fire_id_q <= nxt_fire_id;
		end
	end

	assign id       = id_q;
	assign interval = interval_q;
	assign elapsed  = elapsed_q;
	assign fire     = fire_q;
	assign fire_id  = fire_id_q;

endmodule

FILE: src/multi_timer_table_core.sv
// Add, remove, clear and disabled tick: the status beat appears in the cycle after the
// item is taken, and busy stays low, so one such item is taken every cycle.
// Enabled tick: busy goes high and the fire chain drains through the head cell one cell
// per cycle until no fire flag is left; fired beats come first, the status beat last.
// Reset empties the table, sets the tick enable en_q to 1 and clears the result strobe.
// Result beats are shown for a single cycle; the receiver cannot stall.
module multi_timer_table_core #(
	parameter int MAX_TIMERS = mtt_pkg::MAX_TIMERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [mtt_pkg::ID_W-1:0]      timer_id,
	input  logic [mtt_pkg::IVL_W-1:0]     interval,
	input  logic [mtt_pkg::DELTA_W-1:0]   delta,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output logic                          strobe,
	output logic                          kind,
	output logic [mtt_pkg::ID_W-1:0]      fired_id,
	output logic [2:0]                    status,
	output logic                          last
);

	localparam int CNT_W = $clog2(MAX_TIMERS + 1);

	mtt_pkg::state_t    state_q, state_d;
	mtt_pkg::op_t       op;
	mtt_pkg::cell_ctrl_t ctrl;
	mtt_pkg::status_t   status_q, status_d;

	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               en_q;
	logic               accept;
	logic               found;
	logic               full;
	logic               any_fire;
	logic               add_go, rem_go, tick_go, emit_shift;

	logic               strobe_q, strobe_d;
	logic               kind_q, kind_d;
	logic [mtt_pkg::ID_W-1:0] fired_id_q, fired_id_d;
	logic               last_q, last_d;

	logic [MAX_TIMERS-1:0]    valid, load_sel, match_in, match_out, fire, nxt_fire;
	logic [mtt_pkg::ID_W-1:0]   c_id      [MAX_TIMERS];
	logic [mtt_pkg::IVL_W-1:0]  c_ivl     [MAX_TIMERS];
	logic [mtt_pkg::ELAP_W-1:0] c_elap    [MAX_TIMERS];
	logic [mtt_pkg::ID_W-1:0]   c_fire_id [MAX_TIMERS];
	logic [mtt_pkg::ID_W-1:0]   n_id      [MAX_TIMERS];
	logic [mtt_pkg::IVL_W-1:0]  n_ivl     [MAX_TIMERS];
	logic [mtt_pkg::ELAP_W-1:0] n_elap    [MAX_TIMERS];
	logic [mtt_pkg::ID_W-1:0]   n_fire_id [MAX_TIMERS];

	assign op       = mtt_pkg::op_t'(operation);
	assign busy     = (state_q == mtt_pkg::S_EMIT);
	assign accept   = start && !busy;
	assign found    = match_out[MAX_TIMERS-1];
	assign full     = (cnt_q == CNT_W'(MAX_TIMERS));
	assign any_fire = |fire;

	// Commands to the cell row.
	assign ctrl.add          = add_go;
	assign ctrl.remove       = rem_go;
	assign ctrl.tick         = tick_go;
	assign ctrl.emit_shift   = emit_shift;
	assign ctrl.key_id       = timer_id;
	assign ctrl.new_interval = interval;
	assign ctrl.delta        = delta;

	// Row of cells; each takes its neighbor toward the tail on remove and on drain.
	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		assign valid[i]    = CNT_W'(i) < cnt_q;
		assign load_sel[i] = CNT_W'(i) == cnt_q;

		if (i == 0) begin : g_head
			assign match_in[i] = 1'b0;
		end else begin : g_body
			assign match_in[i] = match_out[i-1];
		end

		if (i == MAX_TIMERS - 1) begin : g_tail
			assign nxt_fire[i]  = 1'b0;
			assign n_fire_id[i] = '0;
			assign n_id[i]      = c_id[i];
			assign n_ivl[i]     = c_ivl[i];
			assign n_elap[i]    = c_elap[i];
		end else begin : g_link
			assign nxt_fire[i]  = fire[i+1];
			assign n_fire_id[i] = c_fire_id[i+1];
			assign n_id[i]      = c_id[i+1];
			assign n_ivl[i]     = c_ivl[i+1];
			assign n_elap[i]    = c_elap[i+1];
		end

		mtt_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.valid        (valid[i]),
			.load_sel     (load_sel[i]),
			.match_in     (match_in[i]),
			.nxt_id       (n_id[i]),
			.nxt_interval (n_ivl[i]),
			.nxt_elapsed  (n_elap[i]),
			.nxt_fire     (nxt_fire[i]),
			.nxt_fire_id  (n_fire_id[i]),
			.id           (c_id[i]),
			.interval     (c_ivl[i]),
			.elapsed      (c_elap[i]),
			.match_out    (match_out[i]),
			.fire         (fire[i]),
			.fire_id      (c_fire_id[i])
		);
	end

	// Sequencer: next state, table commands and the next result beat.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		add_go     = 1'b0;
		rem_go     = 1'b0;
		tick_go    = 1'b0;
		emit_shift = 1'b0;
		strobe_d   = 1'b0;
		kind_d     = 1'b0;
		fired_id_d = '0;
		status_d   = mtt_pkg::ST_OK;
		last_d     = 1'b1;
		unique case (state_q)
			mtt_pkg::S_IDLE: begin
				if (accept) begin
					strobe_d = 1'b1;
					unique case (op)
						mtt_pkg::OP_ADD: begin
							if (found) begin
								status_d = mtt_pkg::ST_DUP;
							end else if (full) begin
								status_d = mtt_pkg::ST_FULL;
							end else begin
								add_go = 1'b1;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						mtt_pkg::OP_REMOVE: begin
							if (!found) begin
								status_d = mtt_pkg::ST_NOT_FOUND;
							end else begin
								rem_go = 1'b1;
								cnt_d  = cnt_q - 1'b1;
							end
						end
						mtt_pkg::OP_TICK: begin
							if (!en_q) begin
								status_d = mtt_pkg::ST_DISABLED;
							end else begin
								tick_go  = 1'b1;
								strobe_d = 1'b0;
								state_d  = mtt_pkg::S_EMIT;
							end
						end
						mtt_pkg::OP_CLEAR: begin
							cnt_d = '0;
						end
					endcase
				end
			end
			mtt_pkg::S_EMIT: begin
				if (any_fire) begin
					// Drain one cell; the head cell's flag says whether a timer fired.
					emit_shift = 1'b1;
					strobe_d   = fire[0];
					kind_d     = 1'b1;
					fired_id_d = c_fire_id[0];
					last_d     = 1'b0;
				end else begin
					strobe_d = 1'b1;
					state_d  = mtt_pkg::S_IDLE;
				end
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mtt_pkg::S_IDLE;
			cnt_q    <= '0;
			en_q     <= 1'b1;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			strobe_q <= strobe_d;
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		kind_q     <= kind_d;
		fired_id_q <= fired_id_d;
		status_q   <= status_d;
		last_q     <= last_d;
	end

	assign strobe   = strobe_q;
	assign kind     = kind_q;
	assign fired_id = fired_id_q;
	assign status   = status_q;
	assign last     = last_q;

	// The table never holds more entries than there are cells.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_TIMERS))
		else $error("entry count beyond table depth");

	// A fired beat is never the final beat of its item.
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind |-> !last)
		else $error("fired beat marked last");

	// Items other than an enabled tick give their status beat in the next cycle.
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !(op == mtt_pkg::OP_TICK && en_q) |=> strobe && last && !kind)
		else $error("missing status beat");

	// Leaving the drain always shows the closing status beat.
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last && !kind)
		else $error("drain ended without status beat");

endmodule
